>>> design/lcmt_pkg.sv
// ----------------------------------------------------------------------------
// LED colour mixer table - shared definitions
// Table geometry, request codes, arithmetic constants and the command and
// status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package lcmt_pkg;

	localparam int MIXERS = 8;
	localparam int SLOTS  = 8;
	localparam int DEPTH  = MIXERS * SLOTS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SIW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	// Width of one channel sum over all slots of a mixer.
	localparam int SW     = $clog2(SLOTS * 255 + 1);
	// Width of a channel sum multiplied by full level.
	localparam int NW     = SW + 8;

	localparam logic [7:0] FULL_LEVEL   = 8'd255;
	localparam logic [6:0] PCT_FULL     = 7'd100;
	// floor(m / 100) == (m * 41944) >> 22 for every m up to 255 * 100.
	localparam logic [15:0] DIV100_MUL  = 16'd41944;
	localparam int          DIV100_SHIFT = 22;

	localparam logic [2:0] REQ_ADD = 3'd0;
	localparam logic [2:0] REQ_REM = 3'd1;
	localparam logic [2:0] REQ_DIM = 3'd2;
	localparam logic [2:0] REQ_GET = 3'd3;
	localparam logic [2:0] REQ_MIX = 3'd4;

	localparam logic KIND_LEVEL = 1'b0;
	localparam logic KIND_MIX   = 1'b1;

	typedef struct packed {
		logic           load;
		logic           issue;
		logic [SIW-1:0] idx;
		logic           div_start;
		logic           out_load;
	} lcmt_cmd_t;

	typedef struct packed {
		logic has_result;
		logic is_mix;
		logic need_div;
		logic div_busy;
		logic out_free;
	} lcmt_sts_t;

endpackage

>>> design/lcmt_div.sv
// ----------------------------------------------------------------------------
// LED colour mixer table - normalisation divider
// Three restoring division lanes sharing one divisor. Each quotient is known
// to be below 256, so eight steps, one per cycle, produce it.
// ----------------------------------------------------------------------------
module lcmt_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [2:0][lcmt_pkg::NW-1:0]     num,
	input  logic [lcmt_pkg::SW-1:0]          den,
	output logic                             busy,
	output logic [2:0][7:0]                  quo
);
	import lcmt_pkg::*;

	logic [2:0][NW-1:0] rem_q;
	logic [2:0][7:0]    quo_q;
	logic [NW-1:0]      dsh_q;
	logic [2:0]         step_q;
	logic               busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= 3'd7;
		end else if (busy_q) begin
			step_q <= step_q - 3'd1;
			if (step_q == 3'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The shifted divisor walks from den * 128 down to den.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			quo_q <= '0;
			dsh_q <= NW'(den) << 7;
		end else if (busy_q) begin
			for (int c = 0; c < 3; c++) begin
				if (rem_q[c] >= dsh_q) begin
					rem_q[c] <= rem_q[c] - dsh_q;
					quo_q[c] <= {quo_q[c][6:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][6:0], 1'b0};
				end
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

>>> design/lcmt_datapath.sv
// ----------------------------------------------------------------------------
// LED colour mixer table - datapath
// Slot memory with per-entry valid bits, the slot scan pipeline for add,
// remove, dim, brightness lookup and mix, and the result register.
// ----------------------------------------------------------------------------
module lcmt_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  lcmt_pkg::lcmt_cmd_t cmd,
	output lcmt_pkg::lcmt_sts_t sts,
	input  logic [2:0]          req_type,
	input  logic [7:0]          mixer,
	input  logic [23:0]         colour,
	input  logic [7:0]          level,
	input  logic signed [7:0]   dim_percent,
	input  logic [7:0]          floor_level,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic                answer_kind,
	output logic [7:0]          found_level,
	output logic [23:0]         mixed_rgb
);
	import lcmt_pkg::*;

	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'd1 + 17'(x[15:8]);
		return t[15:8];
	endfunction

	// Request registers.
	logic [2:0]  req_q;
	logic [7:0]  mixer_q;
	logic [23:0] colour_q;
	logic [7:0]  level_q;
	logic [6:0]  pabs_q;
	logic        pneg_q;
	logic [7:0]  floor_q;
	logic        live_q;

	// Slot memory.
	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] vbit_q;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    waddr;
	logic [31:0]      wdata;
	logic             we;

	// Read stage.
	logic          v_s1;
	logic          vld_s1;
	logic [31:0]   rdata_s1;
	logic [AW-1:0] addr_s1;
	logic [31:0]   word_s1;

	// Dim stages.
	logic          dv_s2;
	logic [14:0]   m_s2;
	logic [7:0]    lvl_s2;
	logic [23:0]   rgb_s2;
	logic [AW-1:0] addr_s2;
	logic          dv_s3;
	logic [7:0]    q_s3;
	logic [7:0]    lvl_s3;
	logic [23:0]   rgb_s3;
	logic [AW-1:0] addr_s3;
	logic [30:0]   dprod;
	logic [8:0]    dsum;
	logic [7:0]    new_lvl;

	// Mix stage and sums.
	logic            mv_s2;
	logic [2:0][15:0] pr_s2;
	logic [2:0][SW-1:0] acc_q;
	logic [SW-1:0]   top;
	logic [2:0][NW-1:0] num;
	logic            div_busy;
	logic [2:0][7:0] quo;

	// Scan bookkeeping.
	logic       done_q;
	logic [7:0] found_q;
	logic       add_hit;
	logic       rem_hit;
	logic       get_hit;

	// Result register.
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  found_out_q;
	logic [23:0] rgb_out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_type;
			mixer_q  <= mixer;
			colour_q <= colour;
			level_q  <= level;
			floor_q  <= floor_level;
			live_q   <= ({1'b0, mixer} < 9'(MIXERS));
			if (dim_percent > 8'sd100) begin
				pabs_q <= PCT_FULL;
				pneg_q <= 1'b0;
			end else if (dim_percent < -8'sd100) begin
				pabs_q <= PCT_FULL;
				pneg_q <= 1'b1;
			end else if (dim_percent < 8'sd0) begin
				pabs_q <= 7'(8'(-dim_percent));
				pneg_q <= 1'b1;
			end else begin
				pabs_q <= 7'(dim_percent);
				pneg_q <= 1'b0;
			end
		end
	end

	assign raddr = AW'(32'(mixer_q) * SLOTS + 32'(cmd.idx));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	// An entry never written since reset reads as a free slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbit_q <= '0;
		end else if (we) begin
			vbit_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		vld_s1  <= vbit_q[raddr];
		addr_s1 <= raddr;
	end

	assign word_s1 = vld_s1 ? rdata_s1 : 32'd0;

	assign add_hit = v_s1 && (req_q == REQ_ADD) && !done_q && (word_s1 == 32'd0);
	assign rem_hit = v_s1 && (req_q == REQ_REM) && !done_q && (word_s1[23:0] == colour_q);
	assign get_hit = v_s1 && (req_q == REQ_GET) && !done_q && (word_s1[23:0] == colour_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			dv_s2  <= 1'b0;
			dv_s3  <= 1'b0;
			mv_s2  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1  <= cmd.issue && live_q;
			dv_s2 <= v_s1 && (req_q == REQ_DIM) && (word_s1[23:0] != 24'd0);
			dv_s3 <= dv_s2;
			mv_s2 <= v_s1 && (req_q == REQ_MIX);
			if (cmd.load) begin
				done_q <= 1'b0;
			end else if (add_hit || rem_hit || get_hit) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			found_q <= 8'd0;
		end else if (get_hit) begin
			found_q <= word_s1[31:24];
		end
	end

	// Dim: level times percent, then divide by 100 through a reciprocal.
	always_ff @(posedge clk) begin
		m_s2    <= 15'(word_s1[31:24]) * 15'(pabs_q);
		lvl_s2  <= word_s1[31:24];
		rgb_s2  <= word_s1[23:0];
		addr_s2 <= addr_s1;
		q_s3    <= dprod[DIV100_SHIFT +: 8];
		lvl_s3  <= lvl_s2;
		rgb_s3  <= rgb_s2;
		addr_s3 <= addr_s2;
	end

	assign dprod = 31'(m_s2) * 31'(DIV100_MUL);

	always_comb begin
		if (pneg_q) begin
			dsum = {1'b0, lvl_s3} + {1'b0, q_s3};
		end else begin
			dsum = {1'b0, lvl_s3} - {1'b0, q_s3};
		end
		if (dsum < {1'b0, floor_q}) begin
			new_lvl = floor_q;
		end else if (dsum > {1'b0, FULL_LEVEL}) begin
			new_lvl = FULL_LEVEL;
		end else begin
			new_lvl = dsum[7:0];
		end
	end

	// Add and remove write at the read stage, dim two stages later; a request
	// only ever uses one of them.
	assign we    = add_hit || rem_hit || dv_s3;
	assign waddr = dv_s3 ? addr_s3 : addr_s1;
	always_comb begin
		if (dv_s3) begin
			wdata = {new_lvl, rgb_s3};
		end else if (add_hit) begin
			wdata = {level_q, colour_q};
		end else begin
			wdata = 32'd0;
		end
	end

	// Mix: per-channel products, then divide by 255 and accumulate.
	always_ff @(posedge clk) begin
		pr_s2[0] <= 16'(word_s1[23:16]) * 16'(word_s1[31:24]);
		pr_s2[1] <= 16'(word_s1[15:8]) * 16'(word_s1[31:24]);
		pr_s2[2] <= 16'(word_s1[7:0]) * 16'(word_s1[31:24]);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else if (mv_s2) begin
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= acc_q[c] + SW'(div255(pr_s2[c]));
			end
		end
	end

	always_comb begin
		top = acc_q[0];
		if (acc_q[1] > top) begin
			top = acc_q[1];
		end
		if (acc_q[2] > top) begin
			top = acc_q[2];
		end
		for (int c = 0; c < 3; c++) begin
			num[c] = (NW'(acc_q[c]) << 8) - NW'(acc_q[c]);
		end
	end

	lcmt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (top),
		.busy   (div_busy),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (req_q == REQ_MIX) begin
				kind_q      <= KIND_MIX;
				found_out_q <= 8'd0;
				if (top > SW'(FULL_LEVEL)) begin
					rgb_out_q <= {quo[0], quo[1], quo[2]};
				end else begin
					rgb_out_q <= {acc_q[0][7:0], acc_q[1][7:0], acc_q[2][7:0]};
				end
			end else begin
				kind_q      <= KIND_LEVEL;
				found_out_q <= found_q;
				rgb_out_q   <= 24'd0;
			end
		end
	end

	always_comb begin
		sts.has_result = req_q inside {REQ_GET, REQ_MIX};
		sts.is_mix     = (req_q == REQ_MIX);
		sts.need_div   = (top > SW'(FULL_LEVEL));
		sts.div_busy   = div_busy;
		sts.out_free   = !out_valid_q || m_tready;
	end

	assign m_tvalid    = out_valid_q;
	assign answer_kind = kind_q;
	assign found_level = found_out_q;
	assign mixed_rgb   = rgb_out_q;

endmodule

>>> design/lcmt_ctrl.sv
// ----------------------------------------------------------------------------
// LED colour mixer table - controller
// Sequences one request: slot scan, pipeline drain, optional normalisation
// division and hand-off to the result register.
// ----------------------------------------------------------------------------
module lcmt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output lcmt_pkg::lcmt_cmd_t cmd,
	input  lcmt_pkg::lcmt_sts_t sts
);
	import lcmt_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_FINISH = 3'd3;
	localparam logic [2:0] ST_DIVW   = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	// Final drain count, by which the last slot read's write or sum has landed.
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	logic [2:0]     state_q;
	logic [2:0]     state_d;
	logic [SIW-1:0] cnt_q;
	logic [1:0]     dcnt_q;

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.issue     = 1'b0;
		cmd.idx       = cnt_q;
		cmd.div_start = 1'b0;
		cmd.out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (cnt_q == SIW'(SLOTS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (dcnt_q == DRAIN_LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.is_mix && sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIVW;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_DIVW: begin
				if (!sts.div_busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!sts.has_result) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			dcnt_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + SIW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_DRAIN) begin
				dcnt_q <= dcnt_q + 2'd1;
			end else begin
				dcnt_q <= 2'd0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

>>> design/led_colour_mixer_table_core.sv
// ----------------------------------------------------------------------------
// LED colour mixer table - top level
// Keeps a table of mixers with colour slots and serves add, remove, dim,
// brightness lookup and mixed colour requests over streaming channels.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ group: the operation code in s_tuser, its
// operands in s_tdata. Brightness and mix requests return one result on the
// m_ group, with the answer kind in m_tuser; add, remove, dim and unknown
// codes return nothing.
// Each request runs from its transfer to its result as a scan, with one slot
// memory read per cycle while the scan walks the mixer's slots, then a drain
// of the dim and mix pipeline, then a close-out. A mix whose largest channel
// exceeds 255 also passes through the three-lane restoring divider, one
// quotient bit per cycle. s_tready is high only while no request is in
// flight, so a new request is taken only after the controller is done with
// the last one.
// Results sit in an output register; a new request is taken while an
// earlier result still waits, and the controller stalls in its result state
// only where a second result would have to overwrite it. Reset empties every
// slot at once through per-entry valid bits, so no clearing pass is needed.
module led_colour_mixer_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mixer[7:0], colour[31:8], level[39:32], dim_percent[47:40],
	// floor_level[55:48]
	input  logic [55:0] s_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// found_level[7:0], mixed_rgb[31:8]
	output logic [31:0] m_tdata,
	// answer_kind[0]
	output logic        m_tuser
);
	import lcmt_pkg::*;

	lcmt_cmd_t   cmd;
	lcmt_sts_t   sts;
	logic [7:0]  found_level;
	logic [23:0] mixed_rgb;

	lcmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	lcmt_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (s_tuser),
		.mixer       (s_tdata[7:0]),
		.colour      (s_tdata[31:8]),
		.level       (s_tdata[39:32]),
		.dim_percent (s_tdata[47:40]),
		.floor_level (s_tdata[55:48]),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.answer_kind (m_tuser),
		.found_level (found_level),
		.mixed_rgb   (mixed_rgb)
	);

	assign m_tdata = {mixed_rgb, found_level};

endmodule

>>> design/lcmt_checker.sv
// ----------------------------------------------------------------------------
// LED colour mixer table - port checker
// Concurrent checks on the top level's channels, bound to the top level.
// ----------------------------------------------------------------------------
module lcmt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A request transfer keeps the input closed for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken before the scan ran");

	// A brightness answer carries no mixed colour.
	a_level_no_rgb: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:8] == 24'd0)
		else $error("brightness answer with nonzero colour");

	// A mix answer carries no brightness.
	a_mix_no_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0)
		else $error("mix answer with nonzero brightness");

endmodule

bind led_colour_mixer_table_core lcmt_checker u_lcmt_checker (.*);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// LED colour mixer table - testbench
// Drives add, remove, dim, brightness, mix and spare requests into the core
// and predicts every answer with its own copy of the slot table. A short table
// of edge-case requests comes first, then weighted random traffic. Both stream
// sides idle at random, and every answer is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lcmt_pkg::*;

	localparam logic [2:0] REQ_SPARE_LO = 3'd5;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam int RANDOM_REQUESTS = 1425;
	localparam int STALL_LIMIT     = 3000;
	localparam int DRAIN_CYCLES    = 40;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  mixer;
		logic [23:0] colour;
		logic [7:0]  level;
		logic [7:0]  pct;
		logic [7:0]  floor_lv;
	} request_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  level;
		logic [23:0] rgb;
	} answer_t;

	typedef struct packed {
		request_t rq;
		logic     typed;
		answer_t  ans;
	} vector_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;

	logic [31:0] slot_words [DEPTH];
	logic [23:0] palette [12];
	answer_t     answers_due [$];
	answer_t     due_answer;
	int          errors = 0;
	int          idle_cycles = 0;
	int          stall_left = 0;
	int          rx_cycles = 0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;

	// Rows with typed = 1 carry an answer that follows from reset, earlier adds
	// or a range check; the rest are checked against the table prediction.
	vector_t directed_vectors [25] = '{
		'{'{REQ_GET, 8'd0, 24'h123456, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{KIND_LEVEL, 8'h00, 24'h000000}},
		'{'{REQ_MIX, 8'd0, 24'h000000, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{KIND_MIX, 8'h00, 24'h000000}},
		'{'{REQ_ADD, 8'd0, 24'hFFFFFF, 8'hFF, 8'h00, 8'h00}, 1'b0, '0},
		'{'{REQ_ADD, 8'd0, 24'h000000, 8'h80, 8'h00, 8'h00}, 1'b0, '0},
		'{'{REQ_GET, 8'd0, 24'hFFFFFF, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{KIND_LEVEL, 8'hFF, 24'h000000}},
		'{'{REQ_MIX, 8'd0, 24'h000000, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{KIND_MIX, 8'h00, 24'hFFFFFF}},
		'{'{REQ_ADD, 8'd0, 24'hFF0000, 8'hFF, 8'h00, 8'h00}, 1'b0, '0},
		'{'{REQ_MIX, 8'd0, 24'h000000, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{REQ_ADD, 8'd0, 24'h00FF00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{REQ_DIM, 8'd0, 24'h000000, 8'h00, 8'd50, 8'h00}, 1'b0, '0},
		'{'{REQ_DIM, 8'd0, 24'h000000, 8'h00, 8'h9C, 8'h00}, 1'b0, '0},
		'{'{REQ_DIM, 8'd0, 24'h000000, 8'h00, 8'h7F, 8'h10}, 1'b0, '0},
		'{'{REQ_DIM, 8'd0, 24'h000000, 8'h00, 8'h80, 8'h00}, 1'b0, '0},
		'{'{REQ_DIM, 8'd0, 24'h000000, 8'h00, 8'h65, 8'hFF}, 1'b0, '0},
		'{'{REQ_GET, 8'd0, 24'h000000, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{REQ_MIX, 8'd0, 24'h000000, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{REQ_REM, 8'd0, 24'h000000, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{REQ_REM, 8'd0, 24'hABCDEF, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{REQ_ADD, 8'd7, 24'h010203, 8'h01, 8'h00, 8'h00}, 1'b0, '0},
		'{'{REQ_GET, 8'd7, 24'h010203, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{REQ_ADD, 8'd8, 24'hFFFFFF, 8'hFF, 8'h00, 8'h00}, 1'b0, '0},
		'{'{REQ_GET, 8'd8, 24'hFFFFFF, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{KIND_LEVEL, 8'h00, 24'h000000}},
		'{'{REQ_MIX, 8'hFF, 24'h000000, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{KIND_MIX, 8'h00, 24'h000000}},
		'{'{REQ_SPARE_LO, 8'd0, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
		'{'{REQ_SPARE_HI, 8'd0, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0}
	};

	led_colour_mixer_table_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Applies one request to the predicted table; returns 1 when it answers.
	function automatic bit mixer_table_step(input request_t rq, output answer_t ans);
		int unsigned base, r, g, b, top, lv;
		int pct, bv;
		logic [31:0] w;
		bit in_range, done, answered;
		in_range = rq.mixer < MIXERS;
		base = in_range ? rq.mixer * SLOTS : 0;
		pct = $signed(rq.pct);
		if (pct > int'(PCT_FULL))
			pct = int'(PCT_FULL);
		if (pct < -int'(PCT_FULL))
			pct = -int'(PCT_FULL);
		ans = '0;
		done = 1'b0;
		answered = 1'b0;
		case (rq.op)
			REQ_ADD: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (in_range && !done && slot_words[base + s] == 32'd0) begin
						slot_words[base + s] = {rq.level, rq.colour};
						done = 1'b1;
					end
				end
			end
			REQ_REM: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (in_range && !done && slot_words[base + s][23:0] == rq.colour) begin
						slot_words[base + s] = 32'd0;
						done = 1'b1;
					end
				end
			end
			REQ_DIM: begin
				for (int s = 0; s < SLOTS; s++) begin
					w = slot_words[base + s];
					if (in_range && w[23:0] != 24'd0) begin
						bv = int'(w[31:24]);
						bv = bv - (bv * pct) / int'(PCT_FULL);
						if (bv < int'(rq.floor_lv))
							bv = int'(rq.floor_lv);
						if (bv > int'(FULL_LEVEL))
							bv = int'(FULL_LEVEL);
						slot_words[base + s] = {bv[7:0], w[23:0]};
					end
				end
			end
			REQ_GET: begin
				answered = 1'b1;
				ans.kind = KIND_LEVEL;
				for (int s = 0; s < SLOTS; s++) begin
					if (in_range && !done && slot_words[base + s][23:0] == rq.colour) begin
						ans.level = slot_words[base + s][31:24];
						done = 1'b1;
					end
				end
			end
			REQ_MIX: begin
				answered = 1'b1;
				ans.kind = KIND_MIX;
				r = 0;
				g = 0;
				b = 0;
				for (int s = 0; s < SLOTS; s++) begin
					w = slot_words[base + s];
					lv = w[31:24];
					r += (w[23:16] * lv) / FULL_LEVEL;
					g += (w[15:8] * lv) / FULL_LEVEL;
					b += (w[7:0] * lv) / FULL_LEVEL;
				end
				top = r;
				if (g > top)
					top = g;
				if (b > top)
					top = b;
				// Scale all three channels together so the hue is kept.
				if (top > FULL_LEVEL) begin
					r = (r * FULL_LEVEL) / top;
					g = (g * FULL_LEVEL) / top;
					b = (b * FULL_LEVEL) / top;
				end
				if (in_range)
					ans.rgb = {r[7:0], g[7:0], b[7:0]};
			end
			default: ;
		endcase
		return answered;
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			rq.op = REQ_ADD;
		else if (pick < 54)
			rq.op = REQ_REM;
		else if (pick < 64)
			rq.op = REQ_DIM;
		else if (pick < 82)
			rq.op = REQ_GET;
		else if (pick < 96)
			rq.op = REQ_MIX;
		else
			rq.op = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
		if (MIXERS < 256 && $urandom_range(0, 99) < 8)
			rq.mixer = 8'($urandom_range(MIXERS, 255));
		else
			rq.mixer = 8'($urandom_range(0, MIXERS - 1));
		// Mostly reuse a small set of colors so removes and lookups hit.
		if ($urandom_range(0, 99) < 85)
			rq.colour = palette[$urandom_range(0, 11)];
		else
			rq.colour = 24'($urandom);
		rq.level = 8'($urandom);
		if ($urandom_range(0, 99) < 80)
			rq.pct = 8'(int'($urandom_range(0, 200)) - 100);
		else
			rq.pct = 8'($urandom);
		rq.floor_lv = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 40)) : 8'($urandom);
		return rq;
	endfunction

	task automatic send_request(input request_t rq, input logic typed, input answer_t typed_ans);
		answer_t ans;
		int unsigned gap, pick;
		@(negedge clk);
		s_tdata  <= {rq.floor_lv, rq.pct, rq.level, rq.colour, rq.mixer};
		s_tuser  <= rq.op;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		if (mixer_table_step(rq, ans))
			answers_due.push_back(typed ? typed_ans : ans);
		pick = $urandom_range(0, 99);
		if (tx_calm || pick < 60)
			gap = 0;
		else if (pick < 93)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			errors++;
		end
	endtask

	always @(negedge clk) begin
		rx_cycles++;
		rx_calm = ((rx_cycles / 700) % 4) == 1;
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
			stall_left = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 3)
				: $urandom_range(10, 60);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (m_tvalid && m_tready) begin
				if (answers_due.size() == 0) begin
					$display("%0t ns: unexpected answer, got kind %0h data %0h", $time,
						m_tuser, m_tdata);
					errors++;
				end else begin
					due_answer = answers_due.pop_front();
					check_field("answer_kind", 32'(due_answer.kind), 32'(m_tuser));
					check_field("found_level", 32'(due_answer.level), 32'(m_tdata[7:0]));
					check_field("mixed_rgb", 32'(due_answer.rgb), 32'(m_tdata[31:8]));
				end
			end
		end
	end

	// Ends the run if the core stops moving transfers on both sides.
	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		for (int k = 0; k < DEPTH; k++)
			slot_words[k] = 32'd0;
		palette[0] = 24'h000000;
		palette[1] = 24'hFFFFFF;
		for (int k = 2; k < 12; k++)
			palette[k] = 24'($urandom);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (directed_vectors[k])
			send_request(directed_vectors[k].rq, directed_vectors[k].typed,
				directed_vectors[k].ans);
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			tx_calm = ((n / 200) % 4) == 3;
			send_request(random_request(), 1'b0, '0);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
